// ----- rtl/core/mera_pkg.sv -----
// constants shared by the midpoint ellipse rasterizer
`default_nettype none
package mera_pkg;
	localparam int NUM_REGS     = 2;
	localparam int REG_CENTER_X = 0;
	localparam int REG_CENTER_Y = 1;
	localparam int CENTER_X_RST = 320;
	localparam int CENTER_Y_RST = 240;
	localparam logic OP_START   = 1'b0;
	localparam logic OP_STEP    = 1'b1;
	localparam int STATE_BITS   = 5;
	typedef logic [STATE_BITS-1:0] state_t;
endpackage
`default_nettype wire

// ----- rtl/core/midpoint_ellipse_rasterizer_unit.sv -----
// midpoint ellipse rasterizer top level with shared multiplier sequencer
//
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata: opcode, radius_a, radius_b
// m        out  m_tvalid/m_tready  m_tdata: pixel_x, pixel_y; m_tlast: last; m_tuser: done_res
// cfg      in   cfg_wen            cfg_index, cfg_wdata
//
// start items, region-1 steps, the step that switches region and region-2 steps all run
// on one shared multiplier; each accepted start or active step then emits four mirrored pixels
// s_tready is high only while the sequencer is idle; m_tready low holds the current pixel
// reset clears the sequencer and sets the centre to its default position
`default_nettype none
module midpoint_ellipse_rasterizer_unit
	import mera_pkg::*;
#(
	parameter int RADIUS_BITS = 10,
	parameter int COORD_BITS  = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// opcode, radius_a, radius_b from bit 0 up
	input  wire logic [((1+2*RADIUS_BITS+7)/8)*8-1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// pixel_x, pixel_y from bit 0 up
	output logic [((2*(COORD_BITS+1)+7)/8)*8-1:0] m_tdata,
	output logic      m_tlast,
	// done_res
	output logic      m_tuser,
	input  wire logic cfg_wen,
	input  wire logic [$clog2(NUM_REGS)-1:0] cfg_index,
	input  wire logic [COORD_BITS-2:0] cfg_wdata
);
	localparam int RB   = RADIUS_BITS;
	localparam int CW   = COORD_BITS - 1;
	localparam int PXW  = COORD_BITS + 1;
	localparam int PTW  = RB + 1;
	localparam int MW   = 2*RB + 4;
	localparam int PW   = 2*MW;
	localparam int OTW  = ((2*PXW+7)/8)*8;
	localparam int SW   = ((PXW > PTW) ? PXW : PTW) + 1;

	localparam state_t ST_IDLE = 5'd0;
	localparam state_t ST_S0   = 5'd1;
	localparam state_t ST_S1   = 5'd2;
	localparam state_t ST_S2   = 5'd3;
	localparam state_t ST_S3   = 5'd4;
	localparam state_t ST_S4   = 5'd5;
	localparam state_t ST_R1A  = 5'd6;
	localparam state_t ST_R1B  = 5'd7;
	localparam state_t ST_R1C  = 5'd8;
	localparam state_t ST_R1D  = 5'd9;
	localparam state_t ST_R1E  = 5'd10;
	localparam state_t ST_W0   = 5'd11;
	localparam state_t ST_W1   = 5'd12;
	localparam state_t ST_W2   = 5'd13;
	localparam state_t ST_W3   = 5'd14;
	localparam state_t ST_W4   = 5'd15;
	localparam state_t ST_R2A  = 5'd16;
	localparam state_t ST_R2B  = 5'd17;
	localparam state_t ST_R2C  = 5'd18;
	localparam state_t ST_EMIT = 5'd19;

	state_t                state_q;
	logic [CW-1:0]         cx_q, cy_q;
	logic [RB-1:0]         ra_q, rb_q;
	logic [2*RB-1:0]       a2_q, b2_q;
	logic [4*RB-1:0]       a2b2_q;
	logic [PTW-1:0]        x_q, y_q;
	logic signed [PW-1:0]  d_q, t_q, prod_q;
	logic                  region_q, active_q, done_q;
	logic [1:0]            k_q;

	logic signed [MW-1:0]  mul_a, mul_b, xs, ys, a2s, b2s, ras, rbs, prod_lo;
	logic signed [PW-1:0]  a2b2x, a2x, b2x;
	logic [PTW-1:0]        y_dec;
	logic                  s_acc, m_acc;
	logic [SW-1:0]         px_w, py_w;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_acc    = m_tvalid && m_tready;

	assign xs      = signed'({{(MW-PTW){1'b0}}, x_q});
	assign ys      = signed'({{(MW-PTW){1'b0}}, y_q});
	assign a2s     = signed'({{(MW-2*RB){1'b0}}, a2_q});
	assign b2s     = signed'({{(MW-2*RB){1'b0}}, b2_q});
	assign ras     = signed'({{(MW-RB){1'b0}}, ra_q});
	assign rbs     = signed'({{(MW-RB){1'b0}}, rb_q});
	assign prod_lo = prod_q[MW-1:0];
	assign a2b2x   = signed'({{(PW-4*RB){1'b0}}, a2b2_q});
	assign a2x     = signed'({{(PW-2*RB){1'b0}}, a2_q});
	assign b2x     = signed'({{(PW-2*RB){1'b0}}, b2_q});
	assign y_dec   = y_q - PTW'(1);

	always_comb begin
		mul_a = ras;
		mul_b = ras;
		case (state_q)
			ST_S0: begin
				mul_a = ras;
				mul_b = ras;
			end
			ST_S1: begin
				mul_a = rbs;
				mul_b = rbs;
			end
			ST_S2: begin
				mul_a = a2s;
				mul_b = rbs;
			end
			ST_S3: begin
				mul_a = a2s;
				mul_b = b2s;
			end
			ST_R1A: begin
				mul_a = a2s;
				mul_b = (ys <<< 1) - MW'(1);
			end
			ST_R1B, ST_R2B: begin
				mul_a = b2s;
				mul_b = (xs <<< 1) + MW'(2);
			end
			ST_R1C: begin
				mul_a = b2s;
				mul_b = (xs <<< 1) + MW'(3);
			end
			ST_R1D: begin
				mul_a = a2s;
				mul_b = MW'(2) - (ys <<< 1);
			end
			ST_W0: begin
				mul_a = (xs <<< 1) + MW'(1);
				mul_b = (xs <<< 1) + MW'(1);
			end
			ST_W1: begin
				mul_a = b2s;
				mul_b = prod_lo;
			end
			ST_W2: begin
				mul_a = ys - MW'(1);
				mul_b = ys - MW'(1);
			end
			ST_W3: begin
				mul_a = a2s;
				mul_b = prod_lo;
			end
			ST_R2A: begin
				mul_a = a2s;
				mul_b = MW'(3) - (ys <<< 1);
			end
			default: begin
				mul_a = ras;
				mul_b = ras;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= CW'(CENTER_X_RST);
			cy_q <= CW'(CENTER_Y_RST);
		end else if (cfg_wen) begin
			if (cfg_index == ($clog2(NUM_REGS))'(REG_CENTER_X))
				cx_q <= cfg_wdata;
			else if (cfg_index == ($clog2(NUM_REGS))'(REG_CENTER_Y))
				cy_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			region_q <= 1'b0;
			active_q <= 1'b0;
			done_q   <= 1'b0;
			k_q      <= 2'd0;
			x_q      <= '0;
			y_q      <= '0;
			d_q      <= '0;
			t_q      <= '0;
			ra_q     <= '0;
			rb_q     <= '0;
			a2_q     <= '0;
			b2_q     <= '0;
			a2b2_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					k_q <= 2'd0;
					if (s_acc) begin
						if (s_tdata[0] == OP_START) begin
							ra_q    <= s_tdata[RB:1];
							rb_q    <= s_tdata[2*RB:RB+1];
							state_q <= ST_S0;
						end else if (active_q) begin
							state_q <= region_q ? ST_R2A : ST_R1A;
						end
					end
				end
				ST_S0: state_q <= ST_S1;
				ST_S1: begin
					a2_q    <= prod_q[2*RB-1:0];
					state_q <= ST_S2;
				end
				ST_S2: begin
					b2_q    <= prod_q[2*RB-1:0];
					state_q <= ST_S3;
				end
				ST_S3: begin
					t_q     <= prod_q;
					state_q <= ST_S4;
				end
				ST_S4: begin
					a2b2_q   <= prod_q[4*RB-1:0];
					d_q      <= (b2x <<< 2) - (t_q <<< 2) + a2x;
					x_q      <= '0;
					y_q      <= PTW'(rb_q);
					region_q <= 1'b0;
					done_q   <= (rb_q == '0);
					active_q <= (rb_q != '0);
					state_q  <= ST_EMIT;
				end
				ST_R1A: state_q <= ST_R1B;
				ST_R1B: begin
					t_q     <= prod_q;
					state_q <= ST_R1C;
				end
				ST_R1C: begin
					if (t_q > prod_q) begin
						state_q <= ST_R1D;
					end else begin
						region_q <= 1'b1;
						state_q  <= ST_W0;
					end
				end
				ST_R1D: begin
					t_q     <= prod_q;
					state_q <= ST_R1E;
				end
				ST_R1E: begin
					x_q <= x_q + PTW'(1);
					if (d_q < 0) begin
						d_q      <= d_q + (t_q <<< 2);
						done_q   <= (y_q == '0);
						active_q <= (y_q != '0);
					end else begin
						d_q      <= d_q + ((t_q + prod_q) <<< 2);
						y_q      <= y_dec;
						done_q   <= (y_dec == '0);
						active_q <= (y_dec != '0);
					end
					state_q <= ST_EMIT;
				end
				ST_W0: state_q <= ST_W1;
				ST_W1: state_q <= ST_W2;
				ST_W2: begin
					d_q     <= prod_q - (a2b2x <<< 2);
					state_q <= ST_W3;
				end
				ST_W3: state_q <= ST_W4;
				ST_W4: begin
					d_q     <= d_q + (prod_q <<< 2);
					state_q <= ST_R2A;
				end
				ST_R2A: state_q <= ST_R2B;
				ST_R2B: begin
					t_q     <= prod_q;
					state_q <= ST_R2C;
				end
				ST_R2C: begin
					if (d_q < 0) begin
						d_q <= d_q + ((prod_q + t_q) <<< 2);
						x_q <= x_q + PTW'(1);
					end else begin
						d_q <= d_q + (t_q <<< 2);
					end
					y_q      <= y_dec;
					done_q   <= (y_dec == '0);
					active_q <= (y_dec != '0);
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					if (m_acc) begin
						k_q <= k_q + 2'd1;
						if (k_q == 2'd3)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// mirrored pixel for the current output slot
	always_comb begin
		if (k_q[0])
			px_w = SW'(cx_q) - SW'(x_q);
		else
			px_w = SW'(cx_q) + SW'(x_q);
		if (k_q[1])
			py_w = SW'(cy_q) - SW'(y_q);
		else
			py_w = SW'(cy_q) + SW'(y_q);
	end

	assign m_tdata = OTW'({py_w[PXW-1:0], px_w[PXW-1:0]});
	assign m_tlast = (k_q == 2'd3);
	assign m_tuser = done_q;
endmodule
`default_nettype wire
